### src/aob_pkg.sv
package aob_pkg;

   localparam int CH_W    = 8;
   localparam int NUM_W   = 24;
   localparam int DIV_W   = 16;
   localparam int LANES   = 4;
   localparam int STEPS   = CH_W;
   localparam int QDEPTH  = 4;
   localparam int QPTR_W  = $clog2(QDEPTH);
   localparam int QCNT_W  = $clog2(QDEPTH + 1);

   localparam logic [CH_W-1:0] FULL_ALPHA = 8'd255;

   // lane order inside a request
   localparam int LANE_ALPHA = 0;
   localparam int LANE_RED   = 1;
   localparam int LANE_GREEN = 2;
   localparam int LANE_BLUE  = 3;

   typedef enum logic [1:0] {
      PATH_PASS   = 2'd0,
      PATH_OPAQUE = 2'd1,
      PATH_OVER   = 2'd2
   } path_type;

   typedef struct packed {
      logic [CH_W-1:0] base_alpha;
      logic [CH_W-1:0] base_red;
      logic [CH_W-1:0] base_green;
      logic [CH_W-1:0] base_blue;
      logic [CH_W-1:0] over_alpha;
      logic [CH_W-1:0] over_red;
      logic [CH_W-1:0] over_green;
      logic [CH_W-1:0] over_blue;
   } pixel_type;

   // one division job: quotient = num / div, always below 256
   typedef struct packed {
      logic [NUM_W-1:0] num;
      logic [DIV_W-1:0] div;
   } lane_type;

   typedef struct packed {
      path_type                path;
      lane_type [LANES-1:0]    lanes;
   } entry_type;

endpackage

### src/aob_front.sv
module aob_front
   import aob_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      in_valid,
   output logic      in_ready,
   input  pixel_type in_pix,
   output logic      out_valid,
   input  logic      out_ready,
   output entry_type out_entry
);

   logic                         accept;
   path_type                     path_in;
   logic [CH_W-1:0]              inv_ao_in;
   logic [2:0][CH_W-1:0]         cb_in;
   logic [2:0][CH_W-1:0]         co_in;
   logic [2:0][2*CH_W-1:0]       cbi_in;
   logic [2:0][2*CH_W-1:0]       coa_in;
   logic [2:0][2*CH_W-1:0]       cbab_in;
   logic [2*CH_W-1:0]            abo_in;

   logic                         a_vld_ff;
   path_type                     path_ff;
   logic [CH_W-1:0]              ab_ff;
   logic [CH_W-1:0]              ao_ff;
   logic [CH_W-1:0]              inv_ao_ff;
   logic [2:0][CH_W-1:0]         co_ff;
   logic [2*CH_W-1:0]            abo_ff;
   logic [2:0][2*CH_W-1:0]       cbi_ff;
   logic [2:0][2*CH_W-1:0]       coa_ff;
   logic [2:0][2*CH_W-1:0]       cbab_ff;

   logic [DIV_W:0]               d_wide;
   logic [DIV_W-1:0]             d;
   logic [2:0][NUM_W-1:0]        over_num;
   logic [2:0][2*CH_W-1:0]       opq_num;

   assign in_ready  = !a_vld_ff || out_ready;
   assign accept    = in_valid && in_ready;
   assign out_valid = a_vld_ff;

   // classify the request by its base color
   always_comb begin
      priority if (in_pix.base_alpha == '0 && in_pix.base_red == '0 &&
                   in_pix.base_green == '0 && in_pix.base_blue == '0) begin
         path_in = PATH_PASS;
      end else if (in_pix.base_alpha == FULL_ALPHA) begin
         path_in = PATH_OPAQUE;
      end else begin
         path_in = PATH_OVER;
      end
   end

   assign inv_ao_in = FULL_ALPHA - in_pix.over_alpha;
   assign cb_in     = {in_pix.base_blue, in_pix.base_green, in_pix.base_red};
   assign co_in     = {in_pix.over_blue, in_pix.over_green, in_pix.over_red};
   assign abo_in    = (2*CH_W)'(in_pix.base_alpha) * (2*CH_W)'(in_pix.over_alpha);

   always_comb begin
      for (int c = 0; c < 3; c++) begin
         cbi_in[c]  = (2*CH_W)'(cb_in[c]) * (2*CH_W)'(inv_ao_in);
         coa_in[c]  = (2*CH_W)'(co_in[c]) * (2*CH_W)'(in_pix.over_alpha);
         cbab_in[c] = (2*CH_W)'(cb_in[c]) * (2*CH_W)'(in_pix.base_alpha);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff <= 1'b0;
      end else if (in_ready) begin
         a_vld_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         path_ff   <= path_in;
         ab_ff     <= in_pix.base_alpha;
         ao_ff     <= in_pix.over_alpha;
         inv_ao_ff <= inv_ao_in;
         co_ff     <= co_in;
         abo_ff    <= abo_in;
         cbi_ff    <= cbi_in;
         coa_ff    <= coa_in;
         cbab_ff   <= cbab_in;
      end
   end

   // combined alpha: 255*ab + 255*ao - ab*ao
   assign d_wide = ((DIV_W+1)'(ab_ff) << CH_W) - (DIV_W+1)'(ab_ff)
                 + ((DIV_W+1)'(ao_ff) << CH_W) - (DIV_W+1)'(ao_ff)
                 - (DIV_W+1)'(abo_ff);
   assign d      = d_wide[DIV_W-1:0];

   always_comb begin
      for (int c = 0; c < 3; c++) begin
         over_num[c] = NUM_W'(cbab_ff[c]) * NUM_W'(inv_ao_ff)
                     + (NUM_W'(coa_ff[c]) << CH_W) - NUM_W'(coa_ff[c]);
         opq_num[c]  = cbi_ff[c] + coa_ff[c];
      end
   end

   always_comb begin
      out_entry.path = path_ff;
      unique case (path_ff)
         PATH_PASS: begin
            out_entry.lanes[LANE_ALPHA] = '{num: NUM_W'(ao_ff), div: DIV_W'(1)};
            for (int c = 0; c < 3; c++) begin
               out_entry.lanes[c+1] = '{num: NUM_W'(co_ff[c]), div: DIV_W'(1)};
            end
         end
         PATH_OPAQUE: begin
            out_entry.lanes[LANE_ALPHA] = '{num: NUM_W'(FULL_ALPHA), div: DIV_W'(1)};
            for (int c = 0; c < 3; c++) begin
               out_entry.lanes[c+1] = '{num: NUM_W'(opq_num[c]),
                                        div: DIV_W'(FULL_ALPHA)};
            end
         end
         default: begin
            out_entry.lanes[LANE_ALPHA] = '{num: NUM_W'(d), div: DIV_W'(FULL_ALPHA)};
            for (int c = 0; c < 3; c++) begin
               // both alphas zero gives zero channels
               if (d == '0) begin
                  out_entry.lanes[c+1] = '{num: '0, div: DIV_W'(1)};
               end else begin
                  out_entry.lanes[c+1] = '{num: over_num[c], div: d};
               end
            end
         end
      endcase
   end

endmodule

### src/aob_queue.sv
module aob_queue
   import aob_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      in_valid,
   output logic      in_ready,
   input  entry_type in_entry,
   output logic      out_valid,
   input  logic      out_ready,
   output entry_type out_entry
);

   entry_type           mem_ff [QDEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff;
   logic [QPTR_W-1:0]   rd_ptr_ff;
   logic [QCNT_W-1:0]   cnt_ff;
   logic [QCNT_W-1:0]   cnt_in;
   logic                push;
   logic                pop;

   assign in_ready  = cnt_ff != QCNT_W'(QDEPTH);
   assign out_valid = cnt_ff != '0;
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;
   assign out_entry = mem_ff[rd_ptr_ff];

   always_comb begin
      cnt_in = cnt_ff;
      if (push && !pop) begin
         cnt_in = cnt_ff + QCNT_W'(1);
      end else if (pop && !push) begin
         cnt_in = cnt_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         cnt_ff <= cnt_in;
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + QPTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + QPTR_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= in_entry;
      end
   end

endmodule

### src/aob_back.sv
module aob_back
   import aob_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       in_valid,
   output logic                       in_ready,
   input  entry_type                  in_entry,
   output logic                       out_valid,
   input  logic                       out_ready,
   output logic [LANES-1:0][CH_W-1:0] out_quot,
   output path_type                   out_path
);

   logic                               en;
   logic [STEPS-1:0]                   vld_ff;
   path_type                           path_ff [STEPS];
   logic [LANES-1:0][CH_W-1:0]         q_ff    [STEPS];
   logic [LANES-1:0][NUM_W-1:0]        rem_ff  [STEPS-1];
   logic [LANES-1:0][DIV_W-1:0]        div_ff  [STEPS-1];

   path_type                           cur_path [STEPS];
   logic [LANES-1:0][CH_W-1:0]         cur_q    [STEPS];
   logic [LANES-1:0][NUM_W-1:0]        cur_rem  [STEPS];
   logic [LANES-1:0][DIV_W-1:0]        cur_div  [STEPS];
   logic [LANES-1:0][NUM_W-1:0]        trial    [STEPS];
   logic [LANES-1:0]                   fits     [STEPS];
   logic [LANES-1:0][CH_W-1:0]         nxt_q    [STEPS];
   logic [LANES-1:0][NUM_W-1:0]        nxt_rem  [STEPS-1];

   assign en        = !vld_ff[STEPS-1] || out_ready;
   assign in_ready  = en;
   assign out_valid = vld_ff[STEPS-1];
   assign out_quot  = q_ff[STEPS-1];
   assign out_path  = path_ff[STEPS-1];

   always_comb begin
      cur_path[0] = in_entry.path;
      for (int l = 0; l < LANES; l++) begin
         cur_q[0][l]   = '0;
         cur_rem[0][l] = in_entry.lanes[l].num;
         cur_div[0][l] = in_entry.lanes[l].div;
      end
      for (int s = 1; s < STEPS; s++) begin
         cur_path[s] = path_ff[s-1];
         cur_q[s]    = q_ff[s-1];
         cur_rem[s]  = rem_ff[s-1];
         cur_div[s]  = div_ff[s-1];
      end
   end

   // restoring division, one quotient bit per stage, msb first
   always_comb begin
      for (int s = 0; s < STEPS; s++) begin
         for (int l = 0; l < LANES; l++) begin
            trial[s][l] = NUM_W'(cur_div[s][l]) << (STEPS - 1 - s);
            fits[s][l]  = cur_rem[s][l] >= trial[s][l];
            nxt_q[s][l] = cur_q[s][l];
            nxt_q[s][l][STEPS-1-s] = fits[s][l];
         end
      end
      for (int s = 0; s < STEPS - 1; s++) begin
         for (int l = 0; l < LANES; l++) begin
            nxt_rem[s][l] = fits[s][l] ? cur_rem[s][l] - trial[s][l] : cur_rem[s][l];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[STEPS-2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int s = 0; s < STEPS; s++) begin
            path_ff[s] <= cur_path[s];
            q_ff[s]    <= nxt_q[s];
         end
         for (int s = 0; s < STEPS - 1; s++) begin
            rem_ff[s] <= nxt_rem[s];
            div_ff[s] <= cur_div[s];
         end
      end
   end

endmodule

### src/argb_alpha_over_blend.sv
// path: a request passes the front register, loaded at the accept edge, then one queue
// slot and the eight divider stages before rsp_valid rises
// throughput: one request per cycle while rsp_ready does not stall, set by the pipelined 8-stage divider
// a 4-entry queue between classifier and divider absorbs rsp_ready stalls
// reset: synchronous, clears all valid flags and the queue, payload not reset
module argb_alpha_over_blend
   import aob_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_base_alpha,
   input  logic [7:0] req_base_red,
   input  logic [7:0] req_base_green,
   input  logic [7:0] req_base_blue,
   input  logic [7:0] req_over_alpha,
   input  logic [7:0] req_over_red,
   input  logic [7:0] req_over_green,
   input  logic [7:0] req_over_blue,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_out_alpha,
   output logic [7:0] rsp_out_red,
   output logic [7:0] rsp_out_green,
   output logic [7:0] rsp_out_blue,
   output logic [1:0] rsp_blend_path
);

   pixel_type                    pix;
   logic                         f_valid;
   logic                         f_ready;
   entry_type                    f_entry;
   logic                         q_valid;
   logic                         q_ready;
   entry_type                    q_entry;
   logic [LANES-1:0][CH_W-1:0]   quot;
   path_type                     path;

   assign pix = '{base_alpha: req_base_alpha, base_red: req_base_red,
                  base_green: req_base_green, base_blue: req_base_blue,
                  over_alpha: req_over_alpha, over_red: req_over_red,
                  over_green: req_over_green, over_blue: req_over_blue};

   aob_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_pix    (pix),
      .out_valid (f_valid),
      .out_ready (f_ready),
      .out_entry (f_entry)
   );

   aob_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (f_valid),
      .in_ready  (f_ready),
      .in_entry  (f_entry),
      .out_valid (q_valid),
      .out_ready (q_ready),
      .out_entry (q_entry)
   );

   aob_back u_back (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (q_valid),
      .in_ready  (q_ready),
      .in_entry  (q_entry),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_quot  (quot),
      .out_path  (path)
   );

   assign rsp_out_alpha  = quot[LANE_ALPHA];
   assign rsp_out_red    = quot[LANE_RED];
   assign rsp_out_green  = quot[LANE_GREEN];
   assign rsp_out_blue   = quot[LANE_BLUE];
   assign rsp_blend_path = path;

endmodule

### tb/argb_alpha_over_blend_check.sv
module argb_alpha_over_blend_check
   import aob_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_ready,
   input  logic [7:0] req_base_alpha,
   input  logic [7:0] req_base_red,
   input  logic [7:0] req_base_green,
   input  logic [7:0] req_base_blue,
   input  logic [7:0] req_over_alpha,
   input  logic [7:0] req_over_red,
   input  logic [7:0] req_over_green,
   input  logic [7:0] req_over_blue,
   input  logic       rsp_valid,
   input  logic       rsp_ready,
   input  logic [7:0] rsp_out_alpha,
   input  logic [7:0] rsp_out_red,
   input  logic [7:0] rsp_out_green,
   input  logic [7:0] rsp_out_blue,
   input  logic [1:0] rsp_blend_path,
   output int         fail_count,
   output int         pending_count
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int REPORT_LIMIT = 10;

   typedef struct packed {
      logic [7:0] alpha;
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      path_type   path;
   } blend_type;

   blend_type blend_q[$];
   int        mismatches = 0;

   function automatic logic [7:0] opaque_channel(logic [7:0] cb, logic [7:0] co,
                                                  logic [7:0] ao);
      logic [31:0] num;
      num = 32'(cb) * (32'(FULL_ALPHA) - 32'(ao)) + 32'(co) * 32'(ao);
      return 8'(num / 32'(FULL_ALPHA));
   endfunction

   function automatic logic [7:0] over_channel(logic [7:0] cb, logic [7:0] ab,
                                                logic [7:0] co, logic [7:0] ao,
                                                logic [31:0] denom);
      logic [31:0] num;
      if (denom == 0) begin
         return 8'd0;
      end
      num = 32'(cb) * 32'(ab) * (32'(FULL_ALPHA) - 32'(ao))
          + 32'(FULL_ALPHA) * 32'(co) * 32'(ao);
      return 8'(num / denom);
   endfunction

   function automatic blend_type blend_predict(pixel_type px);
      blend_type   res;
      logic [31:0] denom;
      if (px.base_alpha == 0 && px.base_red == 0 && px.base_green == 0
          && px.base_blue == 0) begin
         res.alpha = px.over_alpha;
         res.red   = px.over_red;
         res.green = px.over_green;
         res.blue  = px.over_blue;
         res.path  = PATH_PASS;
      end else if (px.base_alpha == FULL_ALPHA) begin
         res.alpha = FULL_ALPHA;
         res.red   = opaque_channel(px.base_red, px.over_red, px.over_alpha);
         res.green = opaque_channel(px.base_green, px.over_green, px.over_alpha);
         res.blue  = opaque_channel(px.base_blue, px.over_blue, px.over_alpha);
         res.path  = PATH_OPAQUE;
      end else begin
         denom = 32'(FULL_ALPHA) * 32'(px.base_alpha)
               + 32'(FULL_ALPHA) * 32'(px.over_alpha)
               - 32'(px.base_alpha) * 32'(px.over_alpha);
         res.alpha = 8'(denom / 32'(FULL_ALPHA));
         res.red   = over_channel(px.base_red, px.base_alpha, px.over_red,
                                  px.over_alpha, denom);
         res.green = over_channel(px.base_green, px.base_alpha, px.over_green,
                                  px.over_alpha, denom);
         res.blue  = over_channel(px.base_blue, px.base_alpha, px.over_blue,
                                  px.over_alpha, denom);
         res.path  = PATH_OVER;
      end
      return res;
   endfunction

   always @(posedge clock) begin : watch
      pixel_type px;
      blend_type want;
      blend_type got;
      if (!reset) begin
         if (req_valid && req_ready) begin
            px = '{req_base_alpha, req_base_red, req_base_green, req_base_blue,
                   req_over_alpha, req_over_red, req_over_green, req_over_blue};
            blend_q.push_back(blend_predict(px));
         end
         if (rsp_valid && rsp_ready) begin
            got = '{rsp_out_alpha, rsp_out_red, rsp_out_green, rsp_out_blue,
                    path_type'(rsp_blend_path)};
            if (blend_q.size() == 0) begin
               mismatches++;
               if (mismatches <= REPORT_LIMIT) begin
                  $display("%0t: response with no request pending: a=%0d r=%0d g=%0d b=%0d path=%0d",
                           $realtime, got.alpha, got.red, got.green, got.blue, got.path);
               end
            end else begin
               want = blend_q.pop_front();
               if (got.alpha !== want.alpha || got.red !== want.red
                   || got.green !== want.green || got.blue !== want.blue
                   || got.path !== want.path) begin
                  mismatches++;
                  if (mismatches <= REPORT_LIMIT) begin
                     $display("%0t: mismatch expected a=%0d r=%0d g=%0d b=%0d path=%0d",
                              $realtime, want.alpha, want.red, want.green, want.blue,
                              want.path);
                     $display("%0t:          actual   a=%0d r=%0d g=%0d b=%0d path=%0d",
                              $realtime, got.alpha, got.red, got.green, got.blue,
                              got.path);
                  end
               end
            end
         end
      end
      fail_count <= mismatches;
      pending_count <= blend_q.size();
   end

endmodule

### tb/argb_alpha_over_blend_test.sv
module argb_alpha_over_blend_test
   import aob_pkg::*;
;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int RANDOM_PIXELS = 900;
   localparam int CYCLE_LIMIT   = 600000;
   localparam int HOLD_CYCLES   = 400;
   localparam int DRAIN_CYCLES  = 40;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic [7:0] req_base_alpha = '0;
   logic [7:0] req_base_red = '0;
   logic [7:0] req_base_green = '0;
   logic [7:0] req_base_blue = '0;
   logic [7:0] req_over_alpha = '0;
   logic [7:0] req_over_red = '0;
   logic [7:0] req_over_green = '0;
   logic [7:0] req_over_blue = '0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic [7:0] rsp_out_alpha;
   logic [7:0] rsp_out_red;
   logic [7:0] rsp_out_green;
   logic [7:0] rsp_out_blue;
   logic [1:0] rsp_blend_path;
   int         fail_count;
   int         pending_count;

   int         sent_count = 0;
   int         cycle_count = 0;
   logic       hold_done = 1'b0;

   argb_alpha_over_blend dut (.*);

   argb_alpha_over_blend_check check (.*);

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("argb_alpha_over_blend_test: FAIL");
         $finish;
      end
   end

   function automatic int idle_cycles();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic pixel_type make_pixel(logic [7:0] ab, logic [7:0] rb,
                                            logic [7:0] gb, logic [7:0] bb,
                                            logic [7:0] ao, logic [7:0] ro,
                                            logic [7:0] go, logic [7:0] bo);
      return '{ab, rb, gb, bb, ao, ro, go, bo};
   endfunction

   function automatic pixel_type random_pixel();
      pixel_type px;
      int        kind;
      px = pixel_type'({$urandom, $urandom});
      kind = $urandom_range(0, 99);
      if (kind < 15) begin
         px.base_alpha = '0;
         px.base_red   = '0;
         px.base_green = '0;
         px.base_blue  = '0;
      end else if (kind < 45) begin
         px.base_alpha = FULL_ALPHA;
      end else if (kind < 55) begin
         px.base_alpha = '0;
         px.over_alpha = '0;
      end else if (kind < 65) begin
         px.over_alpha = $urandom_range(0, 1) ? FULL_ALPHA : 8'd0;
      end else if (kind < 72) begin
         px.base_alpha = 8'($urandom_range(0, 3));
         px.over_alpha = 8'($urandom_range(0, 3));
      end else if (kind < 78) begin
         px.base_alpha = 8'($urandom_range(250, 254));
      end
      return px;
   endfunction

   task automatic send_pixel(input pixel_type px, input int gap);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_base_alpha <= px.base_alpha;
      req_base_red   <= px.base_red;
      req_base_green <= px.base_green;
      req_base_blue  <= px.base_blue;
      req_over_alpha <= px.over_alpha;
      req_over_red   <= px.over_red;
      req_over_green <= px.over_green;
      req_over_blue  <= px.over_blue;
      do @(posedge clock); while (!req_ready);
      sent_count++;
   endtask

   // receiver side, with one long hold-off so the queue fills and the input stalls
   initial begin : rsp_side
      int run_len;
      int stall_len;
      while (reset) @(posedge clock);
      forever begin
         if (!hold_done && sent_count >= 150) begin
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_done = 1'b1;
         end
         run_len = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                                : $urandom_range(1, 8);
         rsp_ready <= 1'b1;
         repeat (run_len) @(posedge clock);
         stall_len = idle_cycles();
         if (stall_len > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall_len) @(posedge clock);
         end
      end
   end

   initial begin : req_side
      pixel_type directed_q[$];
      int        gap;
      int        i;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // transparent base, overlay passed through
      directed_q.push_back(make_pixel(0, 0, 0, 0, 0, 0, 0, 0));
      directed_q.push_back(make_pixel(0, 0, 0, 0, 255, 255, 255, 255));
      directed_q.push_back(make_pixel(0, 0, 0, 0, 128, 1, 254, 77));
      // both alphas zero with some base color: zero denominator
      directed_q.push_back(make_pixel(0, 10, 20, 30, 0, 40, 50, 60));
      directed_q.push_back(make_pixel(0, 0, 0, 1, 0, 255, 255, 255));
      directed_q.push_back(make_pixel(0, 255, 255, 255, 0, 0, 0, 0));
      // opaque base
      directed_q.push_back(make_pixel(255, 0, 0, 0, 0, 255, 255, 255));
      directed_q.push_back(make_pixel(255, 255, 255, 255, 255, 255, 255, 255));
      directed_q.push_back(make_pixel(255, 255, 255, 255, 0, 0, 0, 0));
      directed_q.push_back(make_pixel(255, 0, 128, 255, 255, 0, 0, 0));
      directed_q.push_back(make_pixel(255, 200, 100, 50, 1, 0, 255, 7));
      directed_q.push_back(make_pixel(255, 12, 34, 56, 254, 255, 128, 0));
      // alpha over
      directed_q.push_back(make_pixel(0, 1, 2, 3, 255, 255, 255, 255));
      directed_q.push_back(make_pixel(1, 255, 255, 255, 1, 0, 0, 0));
      directed_q.push_back(make_pixel(254, 255, 0, 255, 254, 0, 255, 0));
      directed_q.push_back(make_pixel(254, 255, 255, 255, 0, 0, 0, 0));
      directed_q.push_back(make_pixel(1, 0, 0, 0, 0, 255, 255, 255));
      directed_q.push_back(make_pixel(128, 255, 255, 255, 128, 255, 255, 255));
      directed_q.push_back(make_pixel(100, 50, 150, 250, 200, 25, 125, 225));
      directed_q.push_back(make_pixel(254, 1, 1, 1, 255, 254, 254, 254));
      foreach (directed_q[k]) begin
         send_pixel(directed_q[k], idle_cycles());
      end

      for (i = 0; i < RANDOM_PIXELS; i++) begin
         gap = ((i / 100) % 3 == 1) ? 0 : idle_cycles();
         send_pixel(random_pixel(), gap);
      end
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (fail_count == 0 && pending_count == 0) begin
         $display("argb_alpha_over_blend_test: PASS");
      end else begin
         $display("argb_alpha_over_blend_test: FAIL");
      end
      $finish;
   end

endmodule
